FILE: hdl/klbi_pkg.sv
// ----------------------------------------------------------------------------
// klbi_pkg
// Shared types, constants and helper functions of the k-mer LSH bucket
// insert block: signature geometry, row fill memory sizes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package klbi_pkg;

  // k-mer and signature geometry
  localparam int KMER_W         = 64;
  localparam int BASE_POSITIONS = 8;
  localparam int TAG_BITS       = 2;
  localparam int COLUMNS        = 7;
  localparam int SIG_BITS       = 2 * BASE_POSITIONS;
  localparam int ROW_BITS       = SIG_BITS - TAG_BITS;
  localparam int ROWS           = 1 << ROW_BITS;
  localparam int ROW_CAP_INT    = COLUMNS << TAG_BITS;
  localparam int FILL_W         = $clog2(ROW_CAP_INT + 1);
  localparam int SLOT_W         = 19;
  localparam int TAG_W          = 2;
  localparam int COUNT_W        = 32;

  localparam logic [FILL_W-1:0] ROW_CAP = FILL_W'(ROW_CAP_INT);

  // gather unit: one chunk of the mask per cycle
  localparam int CHUNK_W      = 8;
  localparam int GATHER_STEPS = KMER_W / CHUNK_W;
  localparam int STEP_W       = $clog2(GATHER_STEPS);
  localparam int POP_W        = $clog2(CHUNK_W + 1);
  localparam int CNT_W        = $clog2(SIG_BITS + 1);
  localparam int SIGIDX_W     = $clog2(SIG_BITS);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENC   = 2'd2;

  localparam logic [COUNT_W-1:0] MAX_ENC_RESET = 32'd4000000000;

  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [POP_W-1:0]   pop;
  } pext8_t;

  typedef struct packed {
    logic                done;
    logic [SIG_BITS-1:0] sig;
  } gather_res_t;

  typedef struct packed {
    logic                rd_en;
    logic [ROW_BITS-1:0] rd_row;
    logic                wr_en;
    logic [ROW_BITS-1:0] wr_row;
    logic [FILL_W-1:0]   wr_fill;
  } fill_req_t;

  // pack the value bits under the mask bits, lowest first
  function automatic pext8_t pext8(input logic [CHUNK_W-1:0] val,
                                   input logic [CHUNK_W-1:0] mask);
    pext8_t res;
    res = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (mask[i]) begin
        res.bits = res.bits | (CHUNK_W'(val[i]) << res.pop);
        res.pop  = res.pop + POP_W'(1);
      end
    end
    return res;
  endfunction

  // high-bit plane to the upper word, low-bit plane to the lower word
  function automatic logic [KMER_W-1:0] split_planes(input logic [KMER_W-1:0] code);
    logic [KMER_W/2-1:0] hi;
    logic [KMER_W/2-1:0] lo;
    for (int j = 0; j < KMER_W / 2; j++) begin
      hi[j] = code[2*j+1];
      lo[j] = code[2*j];
    end
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/klbi_gather.sv
// ----------------------------------------------------------------------------
// klbi_gather
// Iterative bit gather: packs the k-mer bits under a mask into a signature,
// one 8-bit chunk of the mask per cycle from the least significant end.
// ----------------------------------------------------------------------------
`default_nettype none

module klbi_gather import klbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KMER_W-1:0] code_i,
  input  logic [KMER_W-1:0] mask_i,
  output gather_res_t       res_o
);

  logic [KMER_W-1:0]   code_q, mask_q;
  logic                busy_q, done_q;
  logic [STEP_W-1:0]   step_q;
  logic [SIG_BITS-1:0] sig_q, sig_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W:0]      cnt_sum;
  logic [SIG_BITS-1:0] sig_add;
  pext8_t              chunk;

  assign chunk   = pext8(code_q[CHUNK_W-1:0], mask_q[CHUNK_W-1:0]);
  assign cnt_sum = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(chunk.pop);
  assign sig_add = SIG_BITS'(chunk.bits) << cnt_q[SIGIDX_W-1:0];

  // bits past the signature width are dropped
  always_comb begin
    sig_d = sig_q;
    if (cnt_q < CNT_W'(SIG_BITS)) begin
      sig_d = sig_q | sig_add;
    end
    cnt_d = (cnt_sum >= (CNT_W+1)'(SIG_BITS)) ? CNT_W'(SIG_BITS) : cnt_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      code_q <= code_i;
      mask_q <= mask_i;
    end else if (busy_q) begin
      code_q <= code_q >> CHUNK_W;
      mask_q <= mask_q >> CHUNK_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      sig_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        sig_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        sig_q  <= sig_d;
        cnt_q  <= cnt_d;
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(GATHER_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.sig  = sig_q;

endmodule

`default_nettype wire

FILE: hdl/klbi_fill_table.sv
// ----------------------------------------------------------------------------
// klbi_fill_table
// Row fill count memory of one table: one read and one write port, read data
// registered, and a clearing sweep over all rows after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module klbi_fill_table import klbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fill_req_t         req_i,
  output logic [FILL_W-1:0] rd_fill_o,
  output logic              ready_o
);

  logic [FILL_W-1:0]   mem [ROWS];
  logic                clr_busy_q;
  logic [ROW_BITS-1:0] clr_row_q;
  logic                wr_en;
  logic [ROW_BITS-1:0] wr_row;
  logic [FILL_W-1:0]   wr_fill;

  assign wr_en   = clr_busy_q | req_i.wr_en;
  assign wr_row  = clr_busy_q ? clr_row_q : req_i.wr_row;
  assign wr_fill = clr_busy_q ? '0 : req_i.wr_fill;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + ROW_BITS'(1);
      if (clr_row_q == ROW_BITS'(ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_row] <= wr_fill;
    end
    if (req_i.rd_en) begin
      rd_fill_o <= mem[req_i.rd_row];
    end
  end

  assign ready_o = ~clr_busy_q;

  a_no_access_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req_i.rd_en && !req_i.wr_en)
    else $error("fill table accessed during clearing sweep");

  a_clear_ends_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("clearing sweep restarted");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |-> req_i.wr_fill <= ROW_CAP && req_i.wr_fill != '0)
    else $error("fill count written out of range");

endmodule

`default_nettype wire

FILE: hdl/kmer_lsh_bucket_insert_top.sv
// ----------------------------------------------------------------------------
// kmer_lsh_bucket_insert_top
// K-mer bucket insertion for an LSH index with two signature tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes a 32-base k-mer code and an
//   array pick bit. Output channel (out_valid_o/out_ready_i) returns one
//   result per k-mer: slot writes and tags of both tables, the sequence
//   number, the split encoding and the append/capacity flags.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the two gather masks and
//   the encoding limit; it is always ready. The user writes it only while the
//   block idles; the block itself does not enforce this. Each k-mer: the
//   gather units walk the 64-bit mask 8 bits a cycle, then the row fill
//   memories take one read and one write; the next k-mer waits for idle.
//   Reset: the 16384 rows of the fill memories are swept to zero, one row per
//   cycle, with in_ready_o low; config writes are taken meanwhile.
//   Output stall: a result waits in the output register; the next k-mer is
//   taken and gathered meanwhile, and holds before its memory read until the
//   output register has been freed.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_lsh_bucket_insert_top import klbi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KMER_W-1:0]    cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KMER_W-1:0]    kmer_code_i,
  input  logic                 array_pick_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 zero_written_o,
  output logic [SLOT_W-1:0]    zero_slot_o,
  output logic [TAG_W-1:0]     zero_tag_o,
  output logic                 one_written_o,
  output logic [SLOT_W-1:0]    one_slot_o,
  output logic [TAG_W-1:0]     one_tag_o,
  output logic [COUNT_W-1:0]   sequence_number_o,
  output logic                 array_select_o,
  output logic [KMER_W-1:0]    split_encoding_o,
  output logic                 encoding_appended_o,
  output logic                 capacity_reached_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_GATHER = 5'b00100,
    S_READ   = 5'b01000,
    S_WRITE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [KMER_W-1:0]  mask_zero_q, mask_one_q;
  logic [COUNT_W-1:0] max_enc_q;
  logic [COUNT_W-1:0] cnt_zero_q, cnt_one_q;

  logic [KMER_W-1:0]  code_q;
  logic               pick_q, full_q;
  logic [COUNT_W-1:0] seq_q;

  logic               out_valid_q;
  logic               in_xfer, out_free;

  gather_res_t        g_zero, g_one;
  fill_req_t          req_zero, req_one;
  logic [FILL_W-1:0]  fill_zero, fill_one;
  logic               rdy_zero, rdy_one;

  logic [ROW_BITS-1:0] row_zero, row_one;
  logic                wr_zero, wr_one, any_wr;
  logic [SLOT_W-1:0]   slot_zero, slot_one;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_zero_q <= '0;
      mask_one_q  <= '0;
      max_enc_q   <= MAX_ENC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MASK_ZERO: mask_zero_q <= cfg_data_i;
        CFG_MASK_ONE:  mask_one_q  <= cfg_data_i;
        CFG_MAX_ENC:   max_enc_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  klbi_gather u_gather_zero (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .code_i  (kmer_code_i),
    .mask_i  (mask_zero_q),
    .res_o   (g_zero)
  );

  klbi_gather u_gather_one (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .code_i  (kmer_code_i),
    .mask_i  (mask_one_q),
    .res_o   (g_one)
  );

  assign row_zero = g_zero.sig[ROW_BITS-1:0];
  assign row_one  = g_one.sig[ROW_BITS-1:0];

  // fill counts arrive registered in the write state
  assign wr_zero   = ~full_q && (fill_zero < ROW_CAP);
  assign wr_one    = ~full_q && (fill_one < ROW_CAP);
  assign any_wr    = wr_zero | wr_one;
  assign slot_zero = SLOT_W'(row_zero) * SLOT_W'(ROW_CAP_INT) + SLOT_W'(fill_zero);
  assign slot_one  = SLOT_W'(row_one) * SLOT_W'(ROW_CAP_INT) + SLOT_W'(fill_one);

  always_comb begin
    req_zero         = '0;
    req_one          = '0;
    req_zero.rd_row  = row_zero;
    req_one.rd_row   = row_one;
    req_zero.wr_row  = row_zero;
    req_one.wr_row   = row_one;
    req_zero.wr_fill = fill_zero + FILL_W'(1);
    req_one.wr_fill  = fill_one + FILL_W'(1);
    if (state_q == S_READ && out_free) begin
      req_zero.rd_en = 1'b1;
      req_one.rd_en  = 1'b1;
    end
    if (state_q == S_WRITE) begin
      req_zero.wr_en = wr_zero;
      req_one.wr_en  = wr_one;
    end
  end

  klbi_fill_table u_fill_zero (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_zero),
    .rd_fill_o (fill_zero),
    .ready_o   (rdy_zero)
  );

  klbi_fill_table u_fill_one (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_one),
    .rd_fill_o (fill_one),
    .ready_o   (rdy_one)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (rdy_zero && rdy_one) state_d = S_IDLE;
      S_IDLE:   if (in_xfer) state_d = S_GATHER;
      S_GATHER: if (g_zero.done) state_d = S_READ;
      // hold until the output register is free for this result
      S_READ:   if (out_free) state_d = S_WRITE;
      S_WRITE:  state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      cnt_zero_q  <= '0;
      cnt_one_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_WRITE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_WRITE && any_wr) begin
        if (pick_q) begin
          cnt_one_q <= cnt_one_q + COUNT_W'(1);
        end else begin
          cnt_zero_q <= cnt_zero_q + COUNT_W'(1);
        end
      end
    end
  end

  // item registers: counts are stable while an item is in flight
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      code_q <= kmer_code_i;
      pick_q <= array_pick_i;
      full_q <= (cnt_zero_q >= max_enc_q) || (cnt_one_q >= max_enc_q);
      seq_q  <= array_pick_i ? cnt_one_q : cnt_zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      zero_written_o      <= wr_zero;
      zero_slot_o         <= wr_zero ? slot_zero : '0;
      zero_tag_o          <= g_zero.sig[SIG_BITS-1 -: TAG_W];
      one_written_o       <= wr_one;
      one_slot_o          <= wr_one ? slot_one : '0;
      one_tag_o           <= g_one.sig[SIG_BITS-1 -: TAG_W];
      sequence_number_o   <= seq_q;
      array_select_o      <= pick_q;
      split_encoding_o    <= split_planes(code_q);
      encoding_appended_o <= any_wr;
      capacity_reached_o  <= full_q;
    end
  end

  a_write_into_free_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> !out_valid_q)
    else $error("result written over a pending output");

  a_one_counter_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(cnt_zero_q) || $stable(cnt_one_q))
    else $error("both sequence counters advanced together");

  a_append_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (encoding_appended_o == (zero_written_o || one_written_o)))
    else $error("append flag disagrees with table writes");

  a_full_blocks_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && capacity_reached_o) |-> !zero_written_o && !one_written_o)
    else $error("table written while capacity reached");

  a_gathers_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_zero.done == g_one.done)
    else $error("gather units out of step");

endmodule

`default_nettype wire
